FILE: design/slip_ipv4_frame_checker_unit_assert.svh
// ----------------------------------------------------------------------------
// slip ipv4 frame checker assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef SLIP_IPV4_FRAME_CHECKER_UNIT_ASSERT_SVH
`define SLIP_IPV4_FRAME_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication
`define SLIPV4_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLIPV4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/slipv4_pkg.sv
// ----------------------------------------------------------------------------
// slipv4_pkg
// shared types and constants of the slip ipv4 frame checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slipv4_pkg;

  localparam logic [7:0] END_CHAR     = 8'hC0;
  localparam logic [7:0] ESC_CHAR     = 8'hDB;
  localparam logic [7:0] ESC_END_CHAR = 8'hDC;
  localparam logic [7:0] ESC_ESC_CHAR = 8'hDD;

  localparam int unsigned COUNT_W  = 17;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 17'h10000;
  localparam logic [COUNT_W-1:0] IPV4_MIN_HEADER = 17'd20;
  localparam logic [3:0] MIN_IHL = 4'd5;

  typedef enum logic [2:0] {
    REASON_OK           = 3'd0,
    REASON_SHORT        = 3'd1,
    REASON_LEN_MISMATCH = 3'd2,
    REASON_IHL_LOW      = 3'd3,
    REASON_HDR_LONG     = 3'd4
  } drop_reason_t;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic         has_byte;
    logic [7:0]   decoded_byte;
    logic [15:0]  byte_index;
    logic         frame_end;
    logic         accepted;
    drop_reason_t drop_reason;
    logic [5:0]   options_length;
    logic [15:0]  payload_length;
    logic [31:0]  dropped_total;
  } result_t;

  // handshake between the pipeline stages
  typedef struct packed {
    logic valid;
    logic fire;
  } stage_ctrl_t;

endpackage

`default_nettype wire

FILE: design/slipv4_in_if.sv
// ----------------------------------------------------------------------------
// slipv4_in_if
// raw byte channel into the frame checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface slipv4_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       last_byte;

  modport source (output valid, output raw_byte, output last_byte, input ready);
  modport sink (input valid, input raw_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: design/slipv4_out_if.sv
// ----------------------------------------------------------------------------
// slipv4_out_if
// result channel out of the frame checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface slipv4_out_if;
  logic        valid;
  logic        ready;
  logic        has_byte;
  logic [7:0]  decoded_byte;
  logic [15:0] byte_index;
  logic        frame_end;
  logic        accepted;
  logic [2:0]  drop_reason;
  logic [5:0]  options_length;
  logic [15:0] payload_length;
  logic [31:0] dropped_total;

  modport source (
    output valid, output has_byte, output decoded_byte, output byte_index,
    output frame_end, output accepted, output drop_reason, output options_length,
    output payload_length, output dropped_total, input ready
  );
  modport sink (
    input valid, input has_byte, input decoded_byte, input byte_index,
    input frame_end, input accepted, input drop_reason, input options_length,
    input payload_length, input dropped_total, output ready
  );
endinterface

`default_nettype wire

FILE: design/slipv4_in_stage.sv
// ----------------------------------------------------------------------------
// slipv4_in_stage
// input register for raw bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slipv4_in_stage (
  input  wire logic                     clk,
  input  wire logic                     rst,
  slipv4_in_if.sink                     raw,
  input  wire logic                     fire,
  output      logic                     valid,
  output      slipv4_pkg::item_t        item
);
  import slipv4_pkg::*;

  logic load;

  assign raw.ready = !valid || fire;
  assign load      = raw.valid && raw.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (fire) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.raw_byte  <= raw.raw_byte;
      item.last_byte <= raw.last_byte;
    end
  end

endmodule

`default_nettype wire

FILE: design/slipv4_core.sv
// ----------------------------------------------------------------------------
// slipv4_core
// unescaping, header capture, ipv4 checks and drop counting
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "slip_ipv4_frame_checker_unit_assert.svh"

module slipv4_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire slipv4_pkg::stage_ctrl_t  ctrl,
  input  wire slipv4_pkg::item_t        item,
  output      logic                     emit,
  output      slipv4_pkg::result_t      res
);
  import slipv4_pkg::*;

  logic                escape_pending;
  logic [COUNT_W-1:0]  decoded_count;
  logic [3:0]          header_words;
  logic [15:0]         total_length_field;
  logic [31:0]         drop_counter;

  logic                escape_pending_next;
  logic [COUNT_W-1:0]  decoded_count_next;
  logic [3:0]          header_words_next;
  logic [15:0]         total_length_field_next;
  logic [31:0]         drop_counter_next;

  logic                take;
  logic [7:0]          dec;
  logic [COUNT_W-1:0]  len;
  logic [3:0]          ihl;
  logic [15:0]         tot;
  logic [COUNT_W-1:0]  hdr;
  drop_reason_t        reason;
  logic                last;

  assign last = item.last_byte;
  assign take = escape_pending || (item.raw_byte != ESC_CHAR);
  assign emit = take || last;

  always_comb begin
    dec = item.raw_byte;
    if (escape_pending) begin
      case (item.raw_byte)
        ESC_END_CHAR: dec = END_CHAR;
        ESC_ESC_CHAR: dec = ESC_CHAR;
        default:      dec = item.raw_byte;
      endcase
    end
  end

  // frame state after taking this byte
  always_comb begin
    len = decoded_count;
    ihl = header_words;
    tot = total_length_field;
    if (take) begin
      if (decoded_count < COUNT_LIMIT) begin
        len = decoded_count + 17'd1;
      end
      if (decoded_count == 17'd0) begin
        ihl = dec[3:0];
      end else if (decoded_count == 17'd2) begin
        tot = {dec, total_length_field[7:0]};
      end else if (decoded_count == 17'd3) begin
        tot = {total_length_field[15:8], dec};
      end
    end
  end

  assign hdr = {11'd0, ihl, 2'b00};

  always_comb begin
    if (len < IPV4_MIN_HEADER) begin
      reason = REASON_SHORT;
    end else if ({1'b0, tot} != len) begin
      reason = REASON_LEN_MISMATCH;
    end else if (ihl < MIN_IHL) begin
      reason = REASON_IHL_LOW;
    end else if (hdr > len) begin
      reason = REASON_HDR_LONG;
    end else begin
      reason = REASON_OK;
    end
  end

  always_comb begin
    escape_pending_next     = escape_pending;
    decoded_count_next      = decoded_count;
    header_words_next       = header_words;
    total_length_field_next = total_length_field;
    drop_counter_next       = drop_counter;
    if (ctrl.fire) begin
      if (last) begin
        escape_pending_next     = 1'b0;
        decoded_count_next      = '0;
        header_words_next       = '0;
        total_length_field_next = '0;
        if (reason != REASON_OK) begin
          drop_counter_next = drop_counter + 32'd1;
        end
      end else begin
        escape_pending_next     = !take;
        decoded_count_next      = len;
        header_words_next       = ihl;
        total_length_field_next = tot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending     <= 1'b0;
      decoded_count      <= '0;
      header_words       <= '0;
      total_length_field <= '0;
      drop_counter       <= '0;
    end else begin
      escape_pending     <= escape_pending_next;
      decoded_count      <= decoded_count_next;
      header_words       <= header_words_next;
      total_length_field <= total_length_field_next;
      drop_counter       <= drop_counter_next;
    end
  end

  always_comb begin
    res.has_byte       = take;
    res.decoded_byte   = take ? dec : 8'd0;
    res.byte_index     = 16'd0;
    if (take) begin
      res.byte_index = decoded_count[16] ? 16'hFFFF : decoded_count[15:0];
    end
    res.frame_end      = last;
    res.accepted       = last && (reason == REASON_OK);
    res.drop_reason    = last ? reason : REASON_OK;
    res.options_length = 6'd0;
    res.payload_length = 16'd0;
    if (res.accepted) begin
      res.options_length = hdr[5:0] - 6'd20;
      res.payload_length = len[15:0] - hdr[15:0];
    end
    res.dropped_total  = drop_counter_next;
  end

  `SLIPV4_ASSERT_NEXT(a_frame_clears, ctrl.fire && last,
    (decoded_count == '0) && !escape_pending, "frame state not cleared at frame end")
  `SLIPV4_ASSERT_NEXT(a_esc_silent, ctrl.fire && !emit, escape_pending,
    "escape introducer did not set pending")
  `SLIPV4_ASSERT_NOW(a_drop_step, !$past(rst),
    (drop_counter == $past(drop_counter)) || (drop_counter == $past(drop_counter) + 32'd1),
    "drop counter moved by more than one")
  `SLIPV4_ASSERT_NOW(a_accept_ok, ctrl.fire && res.accepted,
    res.frame_end && (res.drop_reason == REASON_OK), "accepted frame without ok verdict")

endmodule

`default_nettype wire

FILE: design/slipv4_out_stage.sv
// ----------------------------------------------------------------------------
// slipv4_out_stage
// result register towards the receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slipv4_out_stage (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     load,
  input  wire slipv4_pkg::result_t      res,
  output      logic                     slot_free,
  slipv4_out_if.source                  result
);
  import slipv4_pkg::*;

  result_t held;

  assign slot_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign result.has_byte       = held.has_byte;
  assign result.decoded_byte   = held.decoded_byte;
  assign result.byte_index     = held.byte_index;
  assign result.frame_end      = held.frame_end;
  assign result.accepted       = held.accepted;
  assign result.drop_reason    = held.drop_reason;
  assign result.options_length = held.options_length;
  assign result.payload_length = held.payload_length;
  assign result.dropped_total  = held.dropped_total;

endmodule

`default_nettype wire

FILE: design/slip_ipv4_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// slip_ipv4_frame_checker_unit
// slip byte decoder with ipv4 header verdict per frame
// ----------------------------------------------------------------------------
// usage
//   raw    : one escaped slip byte per item, last_byte set on the final byte
//            of a frame (end delimiters already removed)
//   result : one item per decoded byte; an escape introducer gives none.
//            the item of the final byte carries frame_end and the verdict,
//            even when that byte is a lone trailing escape (has_byte low)
//   path   : a taken raw item is held in the input register, then its result
//            in the result register
//   throughput: one item per cycle while results are taken, set by the single
//            decode and check pass between the two registers
//   reset  : synchronous rst empties both registers, clears the escape and
//            header state and the drop counter
//   stall  : while result is held, one more item is taken into the input
//            register; raw.ready then drops until the result is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slip_ipv4_frame_checker_unit (
  input  wire logic    clk,
  input  wire logic    rst,
  slipv4_in_if.sink    raw,
  slipv4_out_if.source result
);
  import slipv4_pkg::*;

  stage_ctrl_t ctrl;
  item_t       item;
  result_t     res;
  logic        emit;
  logic        slot_free;
  logic        in_valid;
  logic        fire;

  assign fire = in_valid && slot_free;
  assign ctrl = '{valid: in_valid, fire: fire};

  slipv4_in_stage u_in (
    .clk   (clk),
    .rst   (rst),
    .raw   (raw),
    .fire  (fire),
    .valid (in_valid),
    .item  (item)
  );

  slipv4_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .item (item),
    .emit (emit),
    .res  (res)
  );

  slipv4_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && emit),
    .res       (res),
    .slot_free (slot_free),
    .result    (result)
  );

endmodule

`default_nettype wire

FILE: dv/slipv4_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slipv4_result_checker
// watches the raw and result channels of the slip ipv4 frame checker. every
// raw item taken in is run through a cycle-free copy of the decoder and the
// ipv4 header check, and each result item taken out is compared field by
// field against the oldest prediction still waiting
// ----------------------------------------------------------------------------

module slipv4_result_checker (
  input  logic         clk,
  input  logic         rst,
  slipv4_in_if         raw,
  slipv4_out_if        result,
  output int           fail_count,
  output int           outstanding
);
  import slipv4_pkg::*;

  localparam int PRINT_LIMIT = 50;

  // decoder state
  logic        esc_seen;
  logic [16:0] dec_count;
  logic [3:0]  ihl;
  logic [15:0] tot_len;
  logic [31:0] drops;

  result_t expected_q[$];
  result_t want;

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want_v);
    if (got !== want_v)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want_v));
  endtask

  task automatic decode_raw_item(input logic [7:0] raw_b, input logic last);
    result_t      res;
    logic [7:0]   b;
    logic         have;
    logic [16:0]  hdr_bytes;
    drop_reason_t why;
    res  = '0;
    b    = raw_b;
    have = 1'b1;
    if (esc_seen) begin
      esc_seen = 1'b0;
      if (b == ESC_END_CHAR) b = END_CHAR;
      else if (b == ESC_ESC_CHAR) b = ESC_CHAR;
    end else if (b == ESC_CHAR) begin
      have = 1'b0;
      // escape introducer: nothing comes out unless it ends the frame
      if (!last) begin
        esc_seen = 1'b1;
        return;
      end
    end
    if (have) begin
      if (dec_count == 17'd0) ihl = b[3:0];
      else if (dec_count == 17'd2) tot_len[15:8] = b;
      else if (dec_count == 17'd3) tot_len[7:0] = b;
      res.has_byte     = 1'b1;
      res.decoded_byte = b;
      res.byte_index   = dec_count[16] ? 16'hFFFF : dec_count[15:0];
      if (dec_count < COUNT_LIMIT) dec_count++;
    end
    if (last) begin
      hdr_bytes = {11'd0, ihl, 2'b00};
      if (dec_count < IPV4_MIN_HEADER) why = REASON_SHORT;
      else if ({1'b0, tot_len} != dec_count) why = REASON_LEN_MISMATCH;
      else if (ihl < MIN_IHL) why = REASON_IHL_LOW;
      else if (hdr_bytes > dec_count) why = REASON_HDR_LONG;
      else why = REASON_OK;
      res.frame_end   = 1'b1;
      res.drop_reason = why;
      if (why == REASON_OK) begin
        res.accepted       = 1'b1;
        res.options_length = hdr_bytes[5:0] - IPV4_MIN_HEADER[5:0];
        res.payload_length = dec_count[15:0] - hdr_bytes[15:0];
      end else begin
        drops++;
      end
      esc_seen  = 1'b0;
      dec_count = '0;
      ihl       = '0;
      tot_len   = '0;
    end
    res.dropped_total = drops;
    expected_q.push_back(res);
  endtask

  // sampled mid-cycle: everything is driven at the rising edge, so what is
  // seen here is what the next edge will take
  always @(negedge clk) begin
    if (rst) begin
      esc_seen  = 1'b0;
      dec_count = '0;
      ihl       = '0;
      tot_len   = '0;
      drops     = '0;
      expected_q.delete();
    end else begin
      if (raw.valid && raw.ready) decode_raw_item(raw.raw_byte, raw.last_byte);
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_q.pop_front();
          compare_field("has_byte", result.has_byte, want.has_byte);
          compare_field("decoded_byte", result.decoded_byte, want.decoded_byte);
          compare_field("byte_index", result.byte_index, want.byte_index);
          compare_field("frame_end", result.frame_end, want.frame_end);
          compare_field("accepted", result.accepted, want.accepted);
          compare_field("drop_reason", result.drop_reason, want.drop_reason);
          compare_field("options_length", result.options_length, want.options_length);
          compare_field("payload_length", result.payload_length, want.payload_length);
          compare_field("dropped_total", result.dropped_total, want.dropped_total);
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

FILE: dv/slip_ipv4_frame_checker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slip_ipv4_frame_checker_unit_tb
// drives escaped slip frames into the frame checker: a few hand-picked escape
// corner cases, then random frames, mostly well-formed ipv4 headers with
// random options and payload, plus short, mislabelled, bad-ihl and noise
// frames. the idle rate of both sides changes between phases and the
// receiver stalls for long stretches
// ----------------------------------------------------------------------------

module slip_ipv4_frame_checker_unit_tb;
  import slipv4_pkg::*;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int PHASE_ITEMS    = 600;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum int {
    FRAME_GOOD,
    FRAME_SHORT,
    FRAME_BAD_LEN,
    FRAME_LOW_IHL,
    FRAME_LONG_HDR,
    FRAME_NOISE
  } frame_kind_e;

  logic clk;
  logic rst;

  slipv4_in_if  raw_if ();
  slipv4_out_if res_if ();

  int fail_count;
  int outstanding;
  int cycles;
  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int hold_served;
  int stall_left;

  logic [7:0] frame_bytes[$];
  logic [7:0] raw_q[$];

  int send_pcts[3] = '{28, 84, 0};
  int recv_pcts[3] = '{84, 28, 0};

  // lone escape frame, single byte, escaped last byte, then every escape form
  // ending in a trailing lone escape
  item_t directed_items[14] = '{
    '{ESC_CHAR, 1'b1},
    '{8'hFF, 1'b1},
    '{ESC_CHAR, 1'b0}, '{ESC_END_CHAR, 1'b1},
    '{ESC_CHAR, 1'b0}, '{ESC_END_CHAR, 1'b0},
    '{ESC_CHAR, 1'b0}, '{ESC_ESC_CHAR, 1'b0},
    '{ESC_CHAR, 1'b0}, '{8'h41, 1'b0},
    '{END_CHAR, 1'b0}, '{8'h00, 1'b0}, '{8'hFF, 1'b0},
    '{ESC_CHAR, 1'b1}
  };

  slip_ipv4_frame_checker_unit uut (
    .clk    (clk),
    .rst    (rst),
    .raw    (raw_if),
    .result (res_if)
  );

  slipv4_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .raw         (raw_if),
    .result      (res_if),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver, with long hold-offs on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        stall_left  = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0: return END_CHAR;
      1: return ESC_CHAR;
      2: return $urandom_range(1) ? ESC_END_CHAR : ESC_ESC_CHAR;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_raw(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      raw_if.valid <= 1'b0;
      @(posedge clk);
    end
    raw_if.valid     <= 1'b1;
    raw_if.raw_byte  <= b;
    raw_if.last_byte <= last;
    do @(negedge clk); while (!raw_if.ready);
    @(posedge clk);
    items_sent++;
  endtask

  initial begin : stimulus
    frame_kind_e kind;
    int          pick;
    int          ihl;
    int          len;
    int          phase_start;
    bit          hold_done;
    logic [15:0] tot_len;
    logic [7:0]  b;

    rst              = 1'b1;
    raw_if.valid     = 1'b0;
    raw_if.raw_byte  = '0;
    raw_if.last_byte = 1'b0;
    send_idle_pct    = send_pcts[0];
    recv_idle_pct    = recv_pcts[0];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_items[i])
      send_raw(directed_items[i].raw_byte, directed_items[i].last_byte);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = send_pcts[phase];
      recv_idle_pct = recv_pcts[phase];
      phase_start   = items_sent;
      hold_done     = 1'b0;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (!hold_done && items_sent - phase_start >= PHASE_ITEMS / 3) begin
          hold_requests++;
          hold_done = 1'b1;
        end

        pick = $urandom_range(99);
        if (pick < 60) kind = FRAME_GOOD;
        else if (pick < 68) kind = FRAME_SHORT;
        else if (pick < 76) kind = FRAME_BAD_LEN;
        else if (pick < 84) kind = FRAME_LOW_IHL;
        else if (pick < 92) kind = FRAME_LONG_HDR;
        else kind = FRAME_NOISE;

        ihl = $urandom_range(15, 5);
        case (kind)
          FRAME_GOOD:    len = ihl * 4 + $urandom_range(24, 0);
          FRAME_SHORT: begin
            ihl = $urandom_range(15, 0);
            len = $urandom_range(19, 0);
          end
          FRAME_BAD_LEN: len = ihl * 4 + $urandom_range(16, 0);
          FRAME_LOW_IHL: begin
            ihl = $urandom_range(4, 0);
            len = $urandom_range(40, 20);
          end
          FRAME_LONG_HDR: begin
            ihl = $urandom_range(15, 6);
            len = $urandom_range(ihl * 4 - 1, 20);
          end
          default:       len = $urandom_range(48, 0);
        endcase

        frame_bytes.delete();
        repeat (len) frame_bytes.push_back(random_byte());
        raw_q.delete();
        if (kind == FRAME_NOISE) begin
          // raw bytes as they come, escapes and all
          raw_q = frame_bytes;
        end else begin
          tot_len = len[15:0];
          if (kind == FRAME_BAD_LEN) tot_len = tot_len ^ (16'd1 << $urandom_range(15, 0));
          if (len > 0) frame_bytes[0] = {frame_bytes[0][7:4], ihl[3:0]};
          if (len > 3) begin
            frame_bytes[2] = tot_len[15:8];
            frame_bytes[3] = tot_len[7:0];
          end
          foreach (frame_bytes[i]) begin
            b = frame_bytes[i];
            if (b == ESC_CHAR) begin
              raw_q.push_back(ESC_CHAR);
              raw_q.push_back(ESC_ESC_CHAR);
            end else if (b == END_CHAR && $urandom_range(9) != 0) begin
              raw_q.push_back(ESC_CHAR);
              raw_q.push_back(ESC_END_CHAR);
            end else if (b != ESC_END_CHAR && b != ESC_ESC_CHAR && $urandom_range(19) == 0) begin
              // needless escape, passes the byte through
              raw_q.push_back(ESC_CHAR);
              raw_q.push_back(b);
            end else begin
              raw_q.push_back(b);
            end
          end
        end
        if (raw_q.size() == 0 || $urandom_range(9) == 0) raw_q.push_back(ESC_CHAR);
        foreach (raw_q[i]) send_raw(raw_q[i], i == raw_q.size() - 1);
      end
    end
    raw_if.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
